@@ hdl/terq_pkg.sv @@
package terq_pkg;

  localparam int unsigned TimeBits  = 48;
  localparam int unsigned TagBits   = 16;
  localparam int unsigned KindBits  = 3;
  localparam int unsigned CountBits = 6;
  localparam int unsigned MaxOut    = 32;

  typedef enum logic [1:0] {
    ActAddAbs  = 2'd0,
    ActAddOffs = 2'd1,
    ActTick    = 2'd2,
    ActKill    = 2'd3
  } action_e;

  typedef enum logic [KindBits-1:0] {
    KindAdded    = 3'd0,
    KindRejected = 3'd1,
    KindReleased = 3'd2,
    KindNoneDue  = 3'd3,
    KindCleared  = 3'd4
  } kind_e;

  // per-cell view handed to the controller
  typedef struct packed {
    logic                valid;
    logic                staged;
    logic                due;     // due time at or before current time
    logic [TimeBits-1:0] when;
  } cell_stat_t;

endpackage

@@ hdl/terq_if.sv @@
interface terq_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [terq_pkg::TimeBits-1:0]    time_value;
  logic [terq_pkg::TagBits-1:0]     event_tag;
  modport source (output valid, action, time_value, event_tag, input ready);
  modport sink   (input valid, action, time_value, event_tag, output ready);
endinterface

interface terq_out_if;
  logic                             valid;
  logic                             ready;
  logic [terq_pkg::KindBits-1:0]    kind;
  logic [terq_pkg::TagBits-1:0]     event_tag_res;
  logic [terq_pkg::TimeBits-1:0]    due_time;
  logic [terq_pkg::CountBits-1:0]   live_count;
  logic [terq_pkg::CountBits-1:0]   staged_count;
  logic                             last;
  modport source (output valid, kind, event_tag_res, due_time, live_count, staged_count, last,
                  input ready);
  modport sink   (input valid, kind, event_tag_res, due_time, live_count, staged_count, last,
                  output ready);
endinterface

@@ hdl/terq_cell.sv @@
// One slot of the packed table. Shift moves the right neighbour's content in.
module terq_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [terq_pkg::TimeBits-1:0]      now_i,
  input  logic                               write_i,
  input  logic [terq_pkg::TimeBits-1:0]      wr_due_i,
  input  logic [TAG_BITS-1:0]                wr_tag_i,
  input  logic                               shift_i,
  input  logic                               nb_valid_i,
  input  logic [terq_pkg::TimeBits-1:0]      nb_due_i,
  input  logic [TAG_BITS-1:0]                nb_tag_i,
  input  logic                               merge_i,
  input  logic                               clear_i,
  output logic                               valid_o,
  output logic [terq_pkg::TimeBits-1:0]      due_o,
  output logic [TAG_BITS-1:0]                tag_o,
  output terq_pkg::cell_stat_t               stat_o
);
  logic                          valid_q, valid_d, staged_q, staged_d;
  logic [terq_pkg::TimeBits-1:0] due_q, due_d;
  logic [TAG_BITS-1:0]           tag_q, tag_d;

  always_comb begin
    valid_d  = valid_q;
    staged_d = staged_q;
    due_d    = due_q;
    tag_d    = tag_q;
    if (clear_i) begin
      valid_d  = 1'b0;
      staged_d = 1'b0;
    end else if (merge_i) begin
      staged_d = 1'b0;
    end else if (write_i) begin
      valid_d  = 1'b1;
      staged_d = 1'b1;
      due_d    = wr_due_i;
      tag_d    = wr_tag_i;
    end else if (shift_i) begin
      valid_d  = nb_valid_i;
      staged_d = 1'b0;
      due_d    = nb_due_i;
      tag_d    = nb_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      staged_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      staged_q <= staged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    tag_q <= tag_d;
  end

  assign valid_o       = valid_q;
  assign due_o         = due_q;
  assign tag_o         = tag_q;
  assign stat_o.valid  = valid_q;
  assign stat_o.staged = staged_q;
  assign stat_o.due    = valid_q && (due_q <= now_i);
  assign stat_o.when   = due_q;
endmodule

@@ hdl/timed_event_release_queue.sv @@
// channel  | dir | payload
// in_i     | in  | action, time_value, event_tag
// out_o    | out | kind, event_tag_res, due_time, live_count, staged_count, last
// Add and kill: after acceptance the FSM enters StOut, where the result is registered.
// Tick: StTick merges staged cells and advances time. Each released event then takes a
// serial minimum search over the cells in StScan and a shift of the chain in StShift,
// at most 32 releases per tick. Nothing due: StTick, a full StScan pass, then StOut.
// Clearing tick: StTick, then StOut.
// Reset clears valid flags, time and kill flag at once. A stalled output holds the
// search; no new transaction is taken until the last result leaves.
module timed_event_release_queue #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  terq_in_if.sink  in_i,
  terq_out_if.source out_o
);
  localparam int unsigned IdxBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam int unsigned TB = terq_pkg::TimeBits;

  localparam logic [2:0] StIdle = 3'd0, StTick = 3'd1, StScan = 3'd2,
                         StShift = 3'd3, StOut = 3'd4;

  logic [2:0]           st_q, st_d;
  logic [TB-1:0]        now_q;
  logic                 kill_q;
  logic [CntBits-1:0]   live_q, stg_q, due_cnt_q;
  logic [1:0]           act_q;
  logic [TB-1:0]        tv_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [IdxBits-1:0]   scan_q, best_q;
  logic                 found_q;
  logic [5:0]           nrel_q;

  logic                         ov_q, olast_q;
  logic [terq_pkg::KindBits-1:0] okind_q;
  logic [terq_pkg::TagBits-1:0] otag_q;
  logic [TB-1:0]                odue_q;
  logic [CntBits-1:0]           olive_q, ostg_q;

  logic [DEPTH-1:0]     c_valid, c_write, c_shift;
  logic [TB-1:0]        c_due [DEPTH];
  logic [TAG_BITS-1:0]  c_tag [DEPTH];
  terq_pkg::cell_stat_t c_stat [DEPTH];
  logic                 merge, clear;

  wire  [CntBits-1:0] used = live_q + stg_q;
  wire  [TB-1:0] add_due = (act_q == terq_pkg::ActAddAbs) ? tv_q : now_q + tv_q;
  wire  out_free = !ov_q || out_o.ready;
  wire  [IdxBits-1:0] used_idx = used[IdxBits-1:0];
  wire  is_add = (act_q == terq_pkg::ActAddAbs) || (act_q == terq_pkg::ActAddOffs);

  assign in_i.ready = (st_q == StIdle) && !ov_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic          nv;
    logic [TB-1:0] nd;
    logic [TAG_BITS-1:0] nt;
    if (g + 1 < DEPTH) begin : g_nb
      assign nv = c_valid[g+1];
      assign nd = c_due[g+1];
      assign nt = c_tag[g+1];
    end else begin : g_end
      assign nv = 1'b0;
      assign nd = c_due[g];
      assign nt = c_tag[g];
    end
    assign c_write[g] = (st_q == StOut) && out_free && is_add &&
                        (used < CntBits'(DEPTH)) && (used_idx == IdxBits'(g));
    assign c_shift[g] = (st_q == StShift) && (IdxBits'(g) >= best_q);
    terq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk_i, .rst_ni, .now_i(now_q),
      .write_i(c_write[g]), .wr_due_i(add_due), .wr_tag_i(tag_q),
      .shift_i(c_shift[g]), .nb_valid_i(nv), .nb_due_i(nd), .nb_tag_i(nt),
      .merge_i(merge), .clear_i(clear),
      .valid_o(c_valid[g]), .due_o(c_due[g]), .tag_o(c_tag[g]), .stat_o(c_stat[g])
    );
  end

  assign merge = (st_q == StTick);
  assign clear = (st_q == StTick) && kill_q;

  // serial search candidate
  terq_pkg::cell_stat_t cur;
  assign cur = c_stat[scan_q];
  wire take = cur.due && (!found_q || cur.when < c_stat[best_q].when);

  // due cells seen over the whole pass; one left means this release is the last
  wire [CntBits-1:0] due_tot = due_cnt_q + CntBits'(cur.due);
  wire scan_end = (st_q == StScan) && (scan_q == IdxBits'(DEPTH - 1));
  wire rel_fire = scan_end && (take || found_q) && out_free;
  wire rel_last = (due_tot == CntBits'(1)) || (nrel_q == 6'(terq_pkg::MaxOut - 1));
  wire out_fire = (st_q == StOut) && out_free;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (in_i.valid && in_i.ready) begin
        st_d = (in_i.action == terq_pkg::ActTick) ? StTick : StOut;
      end
      StTick:  st_d = kill_q ? StOut : StScan;
      StScan:  if (scan_end) begin
        if (!(take || found_q)) st_d = StOut;
        else if (out_free) st_d = StShift;
      end
      StShift: st_d = olast_q ? StIdle : StScan;
      StOut:   if (out_free) begin
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; now_q <= '0; kill_q <= 1'b0; live_q <= '0; stg_q <= '0;
      act_q <= '0; tv_q <= '0; tag_q <= '0; due_cnt_q <= '0;
      found_q <= 1'b0; nrel_q <= '0; scan_q <= '0; best_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle: if (in_i.valid && in_i.ready) begin
          act_q <= in_i.action; tv_q <= in_i.time_value;
          tag_q <= TAG_BITS'(in_i.event_tag);
          nrel_q <= '0; scan_q <= '0; found_q <= 1'b0; due_cnt_q <= '0;
        end
        StTick: begin
          now_q <= now_q + tv_q;
          live_q <= kill_q ? '0 : used;
          stg_q <= '0;
        end
        StScan: begin
          if (!scan_end) begin
            if (take) begin
              best_q <= scan_q; found_q <= 1'b1;
            end
            if (cur.due) due_cnt_q <= due_cnt_q + 1'b1;
            scan_q <= scan_q + 1'b1;
          end else if (rel_fire) begin
            if (take) best_q <= scan_q;
            live_q <= live_q - 1'b1;
            nrel_q <= nrel_q + 1'b1;
          end
        end
        StShift: begin
          found_q <= 1'b0; scan_q <= '0; due_cnt_q <= '0;
        end
        StOut: if (out_free) begin
          if (act_q == terq_pkg::ActKill) kill_q <= 1'b1;
          else if (act_q == terq_pkg::ActTick) kill_q <= 1'b0;
          else if (used < CntBits'(DEPTH)) stg_q <= stg_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; olast_q <= 1'b0; okind_q <= terq_pkg::KindAdded;
      otag_q <= '0; odue_q <= '0; olive_q <= '0; ostg_q <= '0;
    end else if (rel_fire) begin
      ov_q    <= 1'b1;
      olast_q <= rel_last;
      okind_q <= terq_pkg::KindReleased;
      otag_q  <= terq_pkg::TagBits'(take ? c_tag[scan_q] : c_tag[best_q]);
      odue_q  <= take ? cur.when : c_stat[best_q].when;
      olive_q <= live_q - 1'b1;
      ostg_q  <= '0;
    end else if (out_fire) begin
      ov_q    <= 1'b1;
      olast_q <= 1'b1;
      olive_q <= live_q;
      case (act_q)
        terq_pkg::ActAddAbs, terq_pkg::ActAddOffs: begin
          otag_q <= terq_pkg::TagBits'(tag_q);
          odue_q <= add_due;
          if (used < CntBits'(DEPTH)) begin
            okind_q <= terq_pkg::KindAdded; ostg_q <= stg_q + 1'b1;
          end else begin
            okind_q <= terq_pkg::KindRejected; ostg_q <= stg_q;
          end
        end
        terq_pkg::ActKill: begin
          okind_q <= terq_pkg::KindCleared; otag_q <= '0; odue_q <= now_q; ostg_q <= stg_q;
        end
        default: begin
          okind_q <= kill_q ? terq_pkg::KindCleared : terq_pkg::KindNoneDue;
          otag_q  <= '0; odue_q <= now_q; ostg_q <= stg_q;
        end
      endcase
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.kind          = okind_q;
  assign out_o.event_tag_res = otag_q;
  assign out_o.due_time      = odue_q;
  assign out_o.live_count    = terq_pkg::CountBits'(olive_q);
  assign out_o.staged_count  = terq_pkg::CountBits'(ostg_q);
  assign out_o.last          = olast_q;
endmodule
